// File: src/ucsf_pkg.sv
// shared types, constants and header byte table for the unconnected send framer
`timescale 1ns / 1ps
package ucsf_pkg;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // frame layout
    localparam logic [3:0]  HEADER_LAST = 4'd9;
    localparam logic [7:0]  HDR_SERVICE = 8'h52;
    localparam logic [7:0]  HDR_PATH_SZ = 8'h02;
    localparam logic [7:0]  HDR_CLASS   = 8'h20;
    localparam logic [7:0]  HDR_CM      = 8'h06;
    localparam logic [7:0]  HDR_INST    = 8'h24;
    localparam logic [7:0]  HDR_INST_ID = 8'h01;
    localparam logic [7:0]  TICK_CODE   = 8'h05;
    localparam logic [17:0] FIXED_BYTES = 18'd12;
    localparam logic [9:0]  MAX_ROUTE   = 10'h1FE;
    localparam logic [11:0] MAX_TICKS   = 12'd255;
    localparam logic [16:0] TICK_ROUND  = 17'd31;
    localparam logic [16:0] CAP_RESET   = 17'h1FFFF;

    // configuration register indexes
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_MSG   = 2'd1,
        OP_ROUTE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_CAPACITY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_MSG   = 2'd1,
        PH_ROUTE = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        K_ERROR     = 3'd0,
        K_HEADER    = 3'd1,
        K_MSG       = 3'd2,
        K_MSG_LAST  = 3'd3,
        K_ROUTE     = 3'd4,
        K_ROUTE_END = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [7:0]  ticks;
        logic [15:0] mlen;
        logic        odd;
        logic [7:0]  words;
        t_status     status;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [7:0] ticks,
                                            input logic [15:0] mlen);
        logic [7:0] b;
        case (idx)
            4'd0:    b = HDR_SERVICE;
            4'd1:    b = HDR_PATH_SZ;
            4'd2:    b = HDR_CLASS;
            4'd3:    b = HDR_CM;
            4'd4:    b = HDR_INST;
            4'd5:    b = HDR_INST_ID;
            4'd6:    b = TICK_CODE;
            4'd7:    b = ticks;
            4'd8:    b = mlen[7:0];
            4'd9:    b = mlen[15:8];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: src/ucsf_front.sv
// front end: accepts items, checks frame starts, tracks phase and pushes commands
`timescale 1ns / 1ps
module ucsf_front import ucsf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_message_length,
    input  logic [9:0]  i_route_length,
    input  logic [15:0] i_req_timeout,
    input  logic [16:0] i_capacity,
    input  t_q_status   i_q_status,
    output logic        o_push,
    output t_cmd        o_cmd
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_msg_rem, n_msg_rem;
    logic [8:0]  r_route_rem, n_route_rem;
    logic        r_odd, n_odd;
    logic [7:0]  r_words, n_words;

    logic        accept;
    logic        bad_arg;
    logic [17:0] total;
    logic [16:0] tick_sum;
    logic [11:0] tick_q;
    logic [7:0]  ticks;
    logic [15:0] msg_dec;
    logic [8:0]  route_dec;

    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;

    assign bad_arg = i_route_length[0] || (i_message_length == 16'd0)
                     || (i_route_length == 10'd0) || (i_route_length > MAX_ROUTE);
    assign total   = FIXED_BYTES + {2'b00, i_message_length} + {17'd0, i_message_length[0]}
                     + {8'd0, i_route_length};
    // ceiling of ms / 32, clamped to 1..255
    assign tick_sum = {1'b0, i_req_timeout} + TICK_ROUND;
    assign tick_q   = tick_sum[16:5];
    assign ticks    = (tick_q == 12'd0) ? 8'd1 :
                      (tick_q > MAX_TICKS) ? MAX_TICKS[7:0] : tick_q[7:0];
    assign msg_dec   = r_msg_rem - 16'd1;
    assign route_dec = r_route_rem - 9'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_msg_rem   <= '0;
            r_route_rem <= '0;
            r_odd       <= 1'b0;
            r_words     <= '0;
        end else begin
            r_phase     <= n_phase;
            r_msg_rem   <= n_msg_rem;
            r_route_rem <= n_route_rem;
            r_odd       <= n_odd;
            r_words     <= n_words;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_msg_rem    = r_msg_rem;
        n_route_rem  = r_route_rem;
        n_odd        = r_odd;
        n_words      = r_words;
        o_push       = 1'b0;
        o_cmd.kind   = K_MSG;
        o_cmd.data   = i_data_byte;
        o_cmd.ticks  = ticks;
        o_cmd.mlen   = i_message_length;
        o_cmd.odd    = r_odd;
        o_cmd.words  = r_words;
        o_cmd.status = ST_OK;
        if (accept) begin
            case (i_operation)
                OP_START: begin
                    o_push      = 1'b1;
                    n_phase     = PH_IDLE;
                    n_msg_rem   = '0;
                    n_route_rem = '0;
                    n_odd       = 1'b0;
                    n_words     = '0;
                    if (bad_arg) begin
                        o_cmd.kind   = K_ERROR;
                        o_cmd.status = ST_INVALID;
                    end else if (total > {1'b0, i_capacity}) begin
                        o_cmd.kind   = K_ERROR;
                        o_cmd.status = ST_CAPACITY;
                    end else begin
                        o_cmd.kind  = K_HEADER;
                        n_phase     = PH_MSG;
                        n_msg_rem   = i_message_length;
                        n_odd       = i_message_length[0];
                        n_route_rem = i_route_length[8:0];
                        n_words     = i_route_length[8:1];
                    end
                end
                OP_MSG: begin
                    if (r_phase == PH_MSG && r_msg_rem != 16'd0) begin
                        o_push    = 1'b1;
                        n_msg_rem = msg_dec;
                        if (msg_dec == 16'd0) begin
                            o_cmd.kind = K_MSG_LAST;
                            n_phase    = PH_ROUTE;
                        end
                    end
                end
                OP_ROUTE: begin
                    if (r_phase == PH_ROUTE && r_route_rem != 9'd0) begin
                        o_push      = 1'b1;
                        o_cmd.kind  = K_ROUTE;
                        n_route_rem = route_dec;
                        if (route_dec == 9'd0) begin
                            o_cmd.kind = K_ROUTE_END;
                            n_phase    = PH_IDLE;
                            n_odd      = 1'b0;
                            n_words    = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: src/ucsf_queue.sv
// small command queue between the front and back ends
`timescale 1ns / 1ps
module ucsf_queue import ucsf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_CW-1:0] r_count;

    assign o_status.full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QUEUE_CW'(1);
                2'b01:   r_count <= r_count - QUEUE_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_status.full && !i_pop) |-> !i_push)
        else $error("queue push while full");

endmodule

// File: src/ucsf_back.sv
// back end: expands queued commands into frame bytes behind an output register
`timescale 1ns / 1ps
module ucsf_back import ucsf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  t_q_status  i_q_status,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic       o_last_of_run,
    output logic       o_frame_end
);

    logic [3:0] r_idx, n_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    t_status    r_stat;
    logic       r_last, r_end;

    logic       can_load, fire, cmd_done;
    logic [3:0] last_idx, pos;
    logic [7:0] c_byte;
    t_status    c_stat;
    logic       c_last, c_end;

    assign can_load = !r_valid || i_out_ready;
    assign fire     = !i_q_status.empty && can_load;
    assign cmd_done = (r_idx == last_idx);
    assign o_pop    = fire && cmd_done;
    assign n_idx    = fire ? (cmd_done ? 4'd0 : r_idx + 4'd1) : r_idx;
    // tail of the message: skip the pad slot when the length is even
    assign pos      = (!i_head.odd && r_idx != 4'd0) ? r_idx + 4'd1 : r_idx;

    always_comb begin
        last_idx = 4'd0;
        c_byte   = i_head.data;
        c_stat   = ST_OK;
        c_last   = 1'b1;
        c_end    = 1'b0;
        case (i_head.kind)
            K_ERROR: begin
                c_byte = 8'h00;
                c_stat = i_head.status;
                c_end  = 1'b1;
            end
            K_HEADER: begin
                last_idx = HEADER_LAST;
                c_byte   = hdr_byte(r_idx, i_head.ticks, i_head.mlen);
                c_last   = (r_idx == HEADER_LAST);
            end
            K_MSG: ;
            K_MSG_LAST: begin
                last_idx = i_head.odd ? 4'd3 : 4'd2;
                c_last   = (pos == 4'd3);
                case (pos)
                    4'd0:    c_byte = i_head.data;
                    4'd2:    c_byte = i_head.words;
                    default: c_byte = 8'h00;
                endcase
            end
            K_ROUTE: ;
            K_ROUTE_END: c_end = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (can_load) begin
                r_valid <= !i_q_status.empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte <= c_byte;
            r_stat <= c_stat;
            r_last <= c_last;
            r_end  <= c_end;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_byte    = r_byte;
    assign o_status      = r_stat;
    assign o_last_of_run = r_last;
    assign o_frame_end   = r_end;

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_stat != ST_OK) |-> (r_byte == 8'h00 && r_end && r_last))
        else $error("error result not a lone zero byte");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_end) |-> r_last)
        else $error("frame end without end of run");

    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_valid && r_last))
        else $error("command retired before its final byte");

endmodule

// File: src/cip_unconnected_send_framer.sv
// top level of the unconnected send request framer
//
//  channel   direction  handshake             payload
//  ------    ---------  --------------------  ---------------------------------------------
//  in        input      i_in_valid/o_in_ready  operation, data_byte, lengths, timeout
//  out       output     o_out_valid/i_out_ready out_byte, status, last_of_run, frame_end
//  cfg       input      apb psel/penable       frame_capacity at byte address 0
//
//  an item is accepted whenever the 4-entry command queue has room
//  each queued command leaves one result per cycle while out is not stalled: a header
//  gives 10 bytes, a message tail 3 or 4, all other commands 1; the back end sets the output rate
//  synchronous active-low reset empties the queue, drops the output and sets
//  the phase to idle; frame_capacity returns to 131071
//  out stalls fill the queue and then hold off input; input idling starves out
`timescale 1ns / 1ps
module cip_unconnected_send_framer import ucsf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_message_length,
    input  logic [9:0]  i_route_length,
    input  logic [15:0] i_req_timeout,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status,
    output logic        o_last_of_run,
    output logic        o_frame_end,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [16:0] r_capacity;
    logic        cfg_wr;
    logic        push, pop;
    t_cmd        cmd, head;
    t_q_status   q_status;

    // register index is the word address; one register lives at index zero
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? {15'd0, r_capacity} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_wr) begin
            r_capacity <= pwdata[16:0];
        end
    end

    // front end: checks, phase tracking, command generation
    ucsf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_data_byte      (i_data_byte),
        .i_message_length (i_message_length),
        .i_route_length   (i_route_length),
        .i_req_timeout    (i_req_timeout),
        .i_capacity       (r_capacity),
        .i_q_status       (q_status),
        .o_push           (push),
        .o_cmd            (cmd)
    );

    // decouples item acceptance from header bursts on the output
    ucsf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (cmd),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // back end: one frame byte per cycle while the output is not stalled, into the output register
    ucsf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run),
        .o_frame_end   (o_frame_end)
    );

endmodule

// File: tb/tb.sv
// self-checking testbench for the unconnected send request framer
`timescale 1ns / 1ps
module tb;
    import ucsf_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_BOUND = 20000;
    localparam int SETTLE      = 40;
    localparam int MAX_PRINTS  = 100;
    localparam int HEADER_LEN  = 10;

    // operation code that the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // frame_capacity register address on the config port
    localparam logic [2:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
    localparam logic [16:0] CAP_MAX = 17'h1FFFF;

    // one result item as the block should present it
    typedef struct packed {
        logic [7:0] data;
        t_status    status;
        logic       last;
        logic       fend;
    } t_frame_out;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n;

    // input channel
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_operation;
    logic [7:0]  i_data_byte;
    logic [15:0] i_message_length;
    logic [9:0]  i_route_length;
    logic [15:0] i_req_timeout;

    // output channel
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_status;
    logic        o_last_of_run;
    logic        o_frame_end;

    // config port
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // expected result items, oldest first
    t_frame_out pending_bytes[$];
    t_frame_out want;

    // framer state as the testbench tracks it
    t_phase      fr_phase      = PH_IDLE;
    logic [15:0] fr_msg_left   = '0;
    logic [8:0]  fr_route_left = '0;
    logic        fr_odd        = 1'b0;
    logic [7:0]  fr_words      = '0;
    logic [16:0] fr_capacity   = CAP_MAX;

    // traffic shaping knobs, percent of cycles spent idle
    int tx_idle_pct  = 25;
    int rx_idle_pct  = 66;
    int hold_request = 0;
    int hold_left    = 0;

    int errors      = 0;
    int cycle_count = 0;
    int items_sent  = 0;

    always #1 i_clk = ~i_clk;

    cip_unconnected_send_framer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_data_byte      (i_data_byte),
        .i_message_length (i_message_length),
        .i_route_length   (i_route_length),
        .i_req_timeout    (i_req_timeout),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_status         (o_status),
        .o_last_of_run    (o_last_of_run),
        .o_frame_end      (o_frame_end),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // ------------------------------------------------------------------
    // error reporting and run limit
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic void queue_result(input logic [7:0] data, input t_status status,
                                         input logic last, input logic fend);
        t_frame_out r;
        r.data   = data;
        r.status = status;
        r.last   = last;
        r.fend   = fend;
        pending_bytes.push_back(r);
    endfunction

    // works out every result item one accepted input item causes
    function automatic void predict_frame_bytes(input logic [1:0] op, input logic [7:0] b,
                                                input logic [15:0] mlen,
                                                input logic [9:0] rlen,
                                                input logic [15:0] tms);
        logic [17:0] total;
        logic [16:0] ticks;
        logic [7:0]  hdr [HEADER_LEN];
        case (op)
            OP_START: begin
                // a start always drops whatever frame was in progress
                fr_phase      = PH_IDLE;
                fr_msg_left   = '0;
                fr_route_left = '0;
                fr_odd        = 1'b0;
                fr_words      = '0;
                if (rlen[0] || mlen == 16'd0 || rlen == 10'd0 || rlen > 10'd510) begin
                    queue_result(8'h00, ST_INVALID, 1'b1, 1'b1);
                end else begin
                    // header, message, pad, word count and reserved byte, route
                    total = 18'(HEADER_LEN + 2) + 18'(mlen) + 18'(mlen[0]) + 18'(rlen);
                    if (total > {1'b0, fr_capacity}) begin
                        queue_result(8'h00, ST_CAPACITY, 1'b1, 1'b1);
                    end else begin
                        // ceiling of ms over 32, kept within 1..255
                        ticks = ({1'b0, tms} + 17'd31) >> 5;
                        if (ticks < 17'd1)
                            ticks = 17'd1;
                        if (ticks > 17'd255)
                            ticks = 17'd255;
                        hdr[0] = 8'h52;     // service code
                        hdr[1] = 8'h02;     // path size in words
                        hdr[2] = 8'h20;     // class segment
                        hdr[3] = 8'h06;     // connection manager
                        hdr[4] = 8'h24;     // instance segment
                        hdr[5] = 8'h01;     // instance one
                        hdr[6] = 8'h05;     // tick time code
                        hdr[7] = ticks[7:0];
                        hdr[8] = mlen[7:0];
                        hdr[9] = mlen[15:8];
                        for (int k = 0; k < HEADER_LEN; k++)
                            queue_result(hdr[k], ST_OK, k == HEADER_LEN - 1, 1'b0);
                        fr_phase      = PH_MSG;
                        fr_msg_left   = mlen;
                        fr_odd        = mlen[0];
                        fr_route_left = rlen[8:0];
                        fr_words      = rlen[8:1];
                    end
                end
            end
            OP_MSG: begin
                if (fr_phase == PH_MSG && fr_msg_left != 16'd0) begin
                    fr_msg_left = fr_msg_left - 16'd1;
                    if (fr_msg_left != 16'd0) begin
                        queue_result(b, ST_OK, 1'b1, 1'b0);
                    end else begin
                        // last message byte brings the tail with it
                        queue_result(b, ST_OK, 1'b0, 1'b0);
                        if (fr_odd)
                            queue_result(8'h00, ST_OK, 1'b0, 1'b0);
                        queue_result(fr_words, ST_OK, 1'b0, 1'b0);
                        queue_result(8'h00, ST_OK, 1'b1, 1'b0);
                        fr_phase = PH_ROUTE;
                    end
                end
            end
            OP_ROUTE: begin
                if (fr_phase == PH_ROUTE && fr_route_left != 9'd0) begin
                    fr_route_left = fr_route_left - 9'd1;
                    if (fr_route_left == 9'd0) begin
                        queue_result(b, ST_OK, 1'b1, 1'b1);
                        fr_phase = PH_IDLE;
                        fr_odd   = 1'b0;
                        fr_words = '0;
                    end else begin
                        queue_result(b, ST_OK, 1'b1, 1'b0);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // output side: receiver readiness and result checking
    // ------------------------------------------------------------------

    // random readiness, or a counted hold-off when a test asks for one
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // each accepted result item against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected item, byte %02h", o_out_byte));
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              o_out_byte, want.data));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_status, want.status));
                if (o_last_of_run !== want.last)
                    report_mismatch($sformatf("last_of_run %0b, want %0b",
                                              o_last_of_run, want.last));
                if (o_frame_end !== want.fend)
                    report_mismatch($sformatf("frame_end %0b, want %0b",
                                              o_frame_end, want.fend));
            end
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // offers one item, called and returning just after a falling edge
    task automatic send_item(input logic [1:0] op, input logic [7:0] b,
                             input logic [15:0] mlen, input logic [9:0] rlen,
                             input logic [15:0] tms);
        // random gap before the item; valid only drops when a gap is taken
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_data_byte      <= b;
        i_message_length <= mlen;
        i_route_length   <= rlen;
        i_req_timeout    <= tms;
        do
            @(posedge i_clk);
        while (o_in_ready !== 1'b1);
        predict_frame_bytes(op, b, mlen, rlen, tms);
        items_sent++;
        @(negedge i_clk);
    endtask

    // message or route byte with the unused fields scrambled
    task automatic send_data(input logic [1:0] op, input logic [7:0] b);
        send_item(op, b, 16'($urandom), 10'($urandom), 16'($urandom));
    endtask

    // byte that the current phase drops: the wrong kind, or the unused code
    task automatic send_noise(input logic [1:0] wrong_op);
        send_data($urandom_range(0, 1) ? OP_UNUSED : wrong_op, 8'($urandom));
    endtask

    // start item followed by nmsg message and nroute route bytes
    task automatic send_frame(input int mlen, input int rlen, input int tms,
                              input int nmsg, input int nroute, input int noise_pct);
        send_item(OP_START, 8'($urandom), 16'(mlen), 10'(rlen), 16'(tms));
        for (int i = 0; i < nmsg; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_noise(OP_ROUTE);
            send_data(OP_MSG, 8'($urandom));
        end
        for (int i = 0; i < nroute; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_noise(OP_MSG);
            send_data(OP_ROUTE, 8'($urandom));
        end
    endtask

    // input goes quiet until every expected item has come, then settles
    task automatic wait_drained();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0 && waited < DRAIN_BOUND) begin
            @(negedge i_clk);
            waited++;
        end
        if (pending_bytes.size() != 0) begin
            report_mismatch($sformatf("%0d items never came", pending_bytes.size()));
            pending_bytes.delete();
        end
        // stray bytes cause no result but may still be in flight
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // config port
    // ------------------------------------------------------------------

    task automatic read_capacity_check();
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= CAP_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (pready !== 1'b1);
        if (prdata !== {15'd0, fr_capacity})
            report_mismatch($sformatf("frame_capacity reads %0h, want %0h",
                                      prdata, fr_capacity));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // write then read back; only called with the block idle
    task automatic write_capacity(input logic [16:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= CAP_ADDR;
        pwdata  <= {15'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (pready !== 1'b1);
        fr_capacity = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        read_capacity_check();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_reset_capacity();
        read_capacity_check();
    endtask

    task automatic test_special_cases();
        send_data(OP_UNUSED, 8'h3C);                              // unknown op while idle
        send_data(OP_MSG, 8'hC3);                                 // stray message byte
        send_data(OP_ROUTE, 8'h81);                               // stray route byte
        send_item(OP_START, 8'h00, 16'd0, 10'd2, 16'd10);         // empty message
        send_item(OP_START, 8'hFF, 16'd1, 10'd3, 16'd10);         // odd route
        send_item(OP_START, 8'h00, 16'd1, 10'd0, 16'd10);         // no route
        send_item(OP_START, 8'h00, 16'd1, 10'd512, 16'd10);       // route too long
        send_item(OP_START, 8'hFF, 16'hFFFF, 10'h3FF, 16'hFFFF);  // all ones
        send_item(OP_START, 8'h00, 16'd1, 10'd2, 16'd0);          // zero ms, one tick
        send_data(OP_ROUTE, 8'h42);                               // route byte too early
        send_data(OP_UNUSED, 8'h00);
        send_data(OP_MSG, 8'h00);                                 // odd length, pad follows
        send_data(OP_MSG, 8'h99);                                 // message byte too late
        send_data(OP_ROUTE, 8'hFF);
        send_data(OP_ROUTE, 8'h00);                               // frame end
        send_item(OP_START, 8'h00, 16'd2, 10'd4, 16'd33);         // rounds up to two ticks
        send_data(OP_MSG, 8'hFF);
        send_item(OP_START, 8'h00, 16'hFFFF, 10'd510, 16'hFFFF);  // restart mid-message
        send_data(OP_MSG, 8'hA5);
        send_data(OP_MSG, 8'h5A);
        send_item(OP_START, 8'h00, 16'd2, 10'd2, 16'd32);         // restart, exactly one tick
        send_data(OP_MSG, 8'h01);
        send_data(OP_MSG, 8'h80);                                 // even length, no pad
        send_data(OP_ROUTE, 8'h7E);
        send_data(OP_ROUTE, 8'hE7);
    endtask

    task automatic test_capacity_limit();
        wait_drained();
        write_capacity(17'd0);
        send_item(OP_START, 8'h00, 16'd1, 10'd2, 16'd100);       // nothing fits
        send_data(OP_MSG, 8'h11);                                 // dropped after the error
        wait_drained();
        write_capacity(17'd20);
        send_frame(3, 4, 500, 3, 4, 0);                           // fills it exactly
        wait_drained();
        write_capacity(17'd19);
        send_item(OP_START, 8'h00, 16'd3, 10'd4, 16'd500);       // one byte over
        wait_drained();
        write_capacity(CAP_MAX);
        send_frame(65535, 510, 65535, 2, 0, 0);                   // largest legal frame
        send_frame(1, 2, 31, 1, 2, 0);
    endtask

    // one random sequence, mostly well-formed frames
    task automatic random_sequence();
        int pick;
        int mlen;
        int rlen;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            mlen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
            rlen = 2 * (($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                                    : $urandom_range(1, 4));
            send_frame(mlen, rlen, $urandom_range(0, 65535), mlen, rlen, 5);
        end else if (pick < 82) begin
            // frame cut short, either in the message or in the route
            if ($urandom_range(0, 1)) begin
                send_frame($urandom_range(1, 65535), 2 * $urandom_range(1, 255),
                           $urandom_range(0, 65535), $urandom_range(0, 3), 0, 5);
            end else begin
                mlen = $urandom_range(1, 6);
                rlen = 2 * $urandom_range(1, 4);
                send_frame(mlen, rlen, $urandom_range(0, 65535), mlen,
                           $urandom_range(0, rlen - 1), 5);
            end
        end else if (pick < 92) begin
            // start with raw fields, mostly rejected
            send_item(OP_START, 8'($urandom),
                      $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom),
                      10'($urandom), 16'($urandom));
        end else begin
            send_item(2'($urandom), 8'($urandom), 16'($urandom), 10'($urandom),
                      16'($urandom));
        end
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input logic [16:0] capacity, input int count);
        int first;
        wait_drained();
        write_capacity(capacity);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        first = items_sent;
        while (items_sent - first < count)
            random_sequence();
    endtask

    // long receiver hold-off fills the block and must stall its input
    task automatic test_output_stall();
        wait_drained();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = 400;
        send_frame(30, 8, 1000, 30, 8, 0);
        // sender stays quiet until every result is out
        wait_drained();
        send_frame(5, 6, 7, 5, 6, 0);
    endtask

    // ------------------------------------------------------------------
    // sequence of tests
    // ------------------------------------------------------------------

    initial begin
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_operation      <= OP_START;
        i_data_byte      <= '0;
        i_message_length <= '0;
        i_route_length   <= '0;
        i_req_timeout    <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_capacity();
        test_special_cases();
        test_capacity_limit();
        test_random_traffic(25, 66, CAP_MAX, 50);
        test_random_traffic(66, 25, 17'($urandom_range(24, 60)), 50);
        test_output_stall();
        test_random_traffic(0, 0, 17'($urandom_range(16, 40)), 50);

        wait_drained();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
src/ucsf_pkg.sv
src/ucsf_front.sv
src/ucsf_queue.sv
src/ucsf_back.sv
src/cip_unconnected_send_framer.sv
tb/tb.sv
